@@ rtl/core/tilt_to_modulation_controls_assert.svh @@
`ifndef TILT_TO_MODULATION_CONTROLS_ASSERT_SVH
`define TILT_TO_MODULATION_CONTROLS_ASSERT_SVH

// Both macros expect aclk and aresetn in scope.
`define TTMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define TTMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tltmod_pkg.sv @@
package tltmod_pkg;

    localparam int ANGLE_STEPS = 32;
    localparam int IDX_W       = $clog2(ANGLE_STEPS);
    localparam int SAMPLE_W    = 16;
    localparam int TILT_SHIFT  = 9;
    localparam int MOD_W       = 5;
    localparam int PORTA_W     = 7;
    localparam int CTRL_W      = 3;

    localparam logic [CTRL_W-1:0] CTRL_MODULATION = 3'd1;
    localparam logic [CTRL_W-1:0] CTRL_PORTAMENTO = 3'd5;

    localparam logic [MOD_W-1:0] MOD_DEPTH_ROM [ANGLE_STEPS] = '{
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd2,
        5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10,
        5'd12, 5'd14, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31
    };

    localparam logic [PORTA_W-1:0] PORTA_ROM [ANGLE_STEPS] = '{
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd10,  7'd20,  7'd30,  7'd40,  7'd50,  7'd60,  7'd70,  7'd70,
        7'd80,  7'd80,  7'd80,  7'd80,  7'd90,  7'd90,  7'd90,  7'd90,
        7'd100, 7'd100, 7'd100, 7'd100, 7'd110, 7'd110, 7'd110, 7'd110
    };

    // Outcome of one item: which messages leave and the new held values.
    typedef struct packed {
        logic               mod_emit;
        logic               porta_emit;
        logic [MOD_W-1:0]   mod_next;
        logic [PORTA_W-1:0] porta_next;
    } tltmod_step_t;

endpackage

@@ rtl/core/tltmod_map.sv @@
module tltmod_map
    import tltmod_pkg::*;
(
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [MOD_W-1:0]    held_mod,
    input  logic [PORTA_W-1:0]  held_porta,
    output tltmod_step_t        step
);

    localparam int MAG_W = SAMPLE_W + 1;
    localparam int TILT_W = MAG_W - TILT_SHIFT;

    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [TILT_W-1:0] tilt;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  mod_idx;
    logic [IDX_W-1:0]  porta_idx;
    logic [MOD_W-1:0]  mod_target;
    logic [PORTA_W-1:0] porta_target;

    assign neg = sample[SAMPLE_W-1];

    // Magnitude in one bit more than the sample so that the most negative value fits.
    always_comb begin
        if (neg) begin
            mag = (MAG_W'(1) << SAMPLE_W) - {1'b0, sample};
        end else begin
            mag = {1'b0, sample};
        end
    end

    assign tilt = mag[MAG_W-1:TILT_SHIFT];
    assign idx  = (tilt >= TILT_W'(ANGLE_STEPS)) ? IDX_W'(ANGLE_STEPS - 1) : tilt[IDX_W-1:0];

    assign mod_idx   = neg ? '0 : idx;
    assign porta_idx = neg ? idx : '0;

    assign mod_target   = MOD_DEPTH_ROM[mod_idx];
    assign porta_target = PORTA_ROM[porta_idx];

    always_comb begin
        step = '0;
        step.mod_next   = held_mod;
        step.porta_next = porta_target;
        if (mod_target > held_mod) begin
            step.mod_emit = 1'b1;
            step.mod_next = held_mod + MOD_W'(1);
        end else if (mod_target < held_mod) begin
            step.mod_emit = 1'b1;
            step.mod_next = held_mod - MOD_W'(1);
        end
        step.porta_emit = (porta_target != held_porta);
    end

endmodule

@@ rtl/core/tltmod_queue.sv @@
module tltmod_queue
    import tltmod_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tltmod_step_t      step,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CTRL_W-1:0] m_controller
);

    `include "tilt_to_modulation_controls_assert.svh"

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [CTRL_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        push_n;
    logic              pop;
    logic [CTRL_W-1:0] first_ctrl;

    assign push_n = push ? (2'(step.mod_emit) + 2'(step.porta_emit)) : 2'd0;
    assign pop    = m_valid && m_ready;
    assign first_ctrl = step.mod_emit ? CTRL_MODULATION : CTRL_PORTAMENTO;

    // Room for a full item of two messages, judged on the registered count.
    assign room         = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign m_valid      = (cnt_reg != '0);
    assign m_controller = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= first_ctrl;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= CTRL_PORTAMENTO;
        end
    end

    `TTMC_ASSERT_SAME(a_push_fits, push_n != 2'd0,
        (cnt_reg + CNT_W'(push_n)) <= CNT_W'(DEPTH), "result queue overflow")
    `TTMC_ASSERT_NEXT(a_count_tracks, pop && (push_n == 2'd0),
        cnt_reg == $past(cnt_reg) - CNT_W'(1), "result count lost a pop")

endmodule

@@ rtl/core/tilt_to_modulation_controls.sv @@
// Tilt to modulation controls.
// Input channel s_valid/s_ready carries one signed 16-bit X-axis sample per item.
// Output channel m_valid/m_ready carries controller numbers, one message per item:
// 1 for a modulation step, 5 for a portamento change; modulation always first.
// An input item may produce zero, one or two messages. The message values are
// the held modulation and portamento levels, kept inside the block.
// A sample accepted into the input register moves into the result queue when
// the queue has room, and its first message is then offered on m_valid.
// Throughput: a sample can be taken every cycle while the queue has room; the
// output sends one message per cycle while m_ready is high, so a stream of samples
// that each give two messages is taken only as fast as those messages leave.
// A four-entry result queue lets new samples enter while earlier messages wait.
// Reset (aresetn low, synchronous) clears both held levels to zero and empties
// the input register and result queue.
// When the receiver stalls, the queue fills; once it holds more than two messages
// a sample in the input register waits and s_ready drops. Nothing is dropped.
module tilt_to_modulation_controls
    import tltmod_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_tilt_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CTRL_W-1:0]   m_controller
);

    `include "tilt_to_modulation_controls_assert.svh"

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [MOD_W-1:0]    held_mod_reg, held_mod_next;
    logic [PORTA_W-1:0]  held_porta_reg, held_porta_next;
    logic                room;
    logic                fire;
    tltmod_step_t        step;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    tltmod_map u_map (
        .sample     (in_sample_reg),
        .held_mod   (held_mod_reg),
        .held_porta (held_porta_reg),
        .step       (step)
    );

    tltmod_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (fire),
        .step         (step),
        .room         (room),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_controller (m_controller)
    );

    always_comb begin
        held_mod_next   = fire ? step.mod_next : held_mod_reg;
        held_porta_next = fire ? step.porta_next : held_porta_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            held_mod_reg   <= '0;
            held_porta_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            held_mod_reg   <= held_mod_next;
            held_porta_reg <= held_porta_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_tilt_sample;
        end
    end

    // The modulation level only ever moves by one step per item.
    `TTMC_ASSERT_NEXT(a_mod_one_step, 1'b1,
        (5'(held_mod_reg - $past(held_mod_reg)) == 5'd0) ||
        (5'(held_mod_reg - $past(held_mod_reg)) == 5'd1) ||
        (5'(held_mod_reg - $past(held_mod_reg)) == 5'd31), "modulation jumped")
    `TTMC_ASSERT_NEXT(a_porta_quiet, !fire, $stable(held_porta_reg),
        "portamento changed without an item")

endmodule

@@ verif/tilt_controls_checker.sv @@
module tilt_controls_checker
    import tltmod_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_tilt_sample,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [CTRL_W-1:0]   m_controller,
    output int                  err_count,
    output int                  pending,
    output int                  mod_seen,
    output int                  porta_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Target curves, kept apart from the package so that a bad ROM shows up.
    localparam logic [MOD_W-1:0] DEPTH_CURVE [ANGLE_STEPS] = '{
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd2,
        5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10,
        5'd12, 5'd14, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31
    };

    localparam logic [PORTA_W-1:0] GLIDE_CURVE [ANGLE_STEPS] = '{
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd10,  7'd20,  7'd30,  7'd40,  7'd50,  7'd60,  7'd70,  7'd70,
        7'd80,  7'd80,  7'd80,  7'd80,  7'd90,  7'd90,  7'd90,  7'd90,
        7'd100, 7'd100, 7'd100, 7'd100, 7'd110, 7'd110, 7'd110, 7'd110
    };

    logic [MOD_W-1:0]   depth_level;
    logic [PORTA_W-1:0] glide_level;
    logic [CTRL_W-1:0]  controls_due [$];

    function automatic logic [4:0] clamp_angle(input logic [6:0] mag);
        return (mag >= 7'(ANGLE_STEPS)) ? 5'(ANGLE_STEPS - 1) : mag[4:0];
    endfunction

    // Updates the held levels for one sample and queues the messages it causes.
    function automatic void predict_controls(input logic [SAMPLE_W-1:0] sample);
        logic [16:0]        neg_mag;
        logic [4:0]         depth_idx;
        logic [4:0]         glide_idx;
        logic [MOD_W-1:0]   depth_goal;
        logic [PORTA_W-1:0] glide_goal;
        depth_idx = '0;
        glide_idx = '0;
        if (sample[SAMPLE_W-1]) begin
            // Truncation toward zero works on the magnitude of a negative sample.
            neg_mag = 17'h10000 - {1'b0, sample};
            glide_idx = clamp_angle(neg_mag[15:9]);
        end else begin
            depth_idx = clamp_angle({1'b0, sample[14:9]});
        end
        depth_goal = DEPTH_CURVE[depth_idx];
        if (depth_goal > depth_level) begin
            depth_level = depth_level + MOD_W'(1);
            controls_due.push_back(CTRL_MODULATION);
        end else if (depth_goal < depth_level) begin
            depth_level = depth_level - MOD_W'(1);
            controls_due.push_back(CTRL_MODULATION);
        end
        glide_goal = GLIDE_CURVE[glide_idx];
        if (glide_goal != glide_level) begin
            glide_level = glide_goal;
            controls_due.push_back(CTRL_PORTAMENTO);
        end
    endfunction

    initial begin
        err_count  = 0;
        pending    = 0;
        mod_seen   = 0;
        porta_seen = 0;
    end

    always @(posedge aclk) begin
        logic [CTRL_W-1:0] want;
        if (!aresetn) begin
            depth_level = '0;
            glide_level = '0;
            controls_due.delete();
        end else begin
            // Results are checked before the new item is predicted, since an item
            // never produces a message at the edge where it is taken.
            if (m_valid && m_ready) begin
                if (controls_due.size() == 0) begin
                    $error("unexpected item: controller %0d", m_controller);
                    err_count++;
                end else begin
                    want = controls_due.pop_front();
                    if (m_controller !== want) begin
                        $error("controller mismatch: expected %0d, actual %0d",
                               want, m_controller);
                        err_count++;
                    end
                    if (want == CTRL_MODULATION) mod_seen++;
                    else porta_seen++;
                end
            end
            if (s_valid && s_ready) predict_controls(s_tilt_sample);
        end
        pending = controls_due.size();
    end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    import tltmod_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_tilt_sample = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [CTRL_W-1:0]   m_controller;

    int          err_count;
    int          pending;
    int          mod_seen;
    int          porta_seen;
    int          samples_sent = 0;
    int          cycle_count  = 0;
    bit          calm         = 1'b0;
    int unsigned ready_hold   = 0;
    int unsigned stall_len;

    tilt_to_modulation_controls dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tilt_sample (s_tilt_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_controller  (m_controller)
    );

    tilt_controls_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tilt_sample (s_tilt_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_controller  (m_controller),
        .err_count     (err_count),
        .pending       (pending),
        .mod_seen      (mod_seen),
        .porta_seen    (porta_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d messages outstanding",
                     cycle_count, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin
        if (calm) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            stall_len = pick_gap();
            if (m_ready && stall_len != 0) begin
                m_ready    <= 1'b0;
                ready_hold <= stall_len - 1;
            end else begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 12);
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_tilt_sample <= value;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    task automatic drain_messages();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // A sample held near one angle: tilt times 512 plus jitter away from zero.
    function automatic logic [SAMPLE_W-1:0] angle_sample(input int tilt);
        int v;
        if (tilt >= 0) v = tilt * 512 + $urandom_range(0, 511);
        else if (tilt == -64) v = -32768;
        else v = tilt * 512 - $urandom_range(0, 511);
        return v[SAMPLE_W-1:0];
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] directed [$];
        int                  tilt;
        int                  run_len;
        int                  v;
        int unsigned         pick;
        bit                  drained;

        directed = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFE01, 16'hFE00,
                     16'hF000, 16'h01FF, 16'h0200, 16'h4000, 16'h7FFF, 16'h7FFF,
                     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1800, 16'hC000, 16'hC000,
                     16'h0000, 16'h0000, 16'h8001, 16'hEE00, 16'h3E00, 16'h0000};
        drained = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Extremes, the small negative band, clamping and idle repeats.
        foreach (directed[i]) send_sample(directed[i]);
        drain_messages();

        while (samples_sent < RANDOM_ITEMS + directed.size()) begin
            calm = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (!drained && samples_sent > RANDOM_ITEMS / 2) begin
                drain_messages();
                drained = 1'b1;
            end
            if (pick < 65) begin
                // Holding one angle lets the modulation level climb or fall.
                case ($urandom_range(0, 9)) inside
                    [0:4]:   tilt = $urandom_range(12, 63);
                    [5:7]:   tilt = -int'($urandom_range(1, 64));
                    default: tilt = int'($urandom_range(0, 127)) - 64;
                endcase
                run_len = $urandom_range(1, 40);
                repeat (run_len) send_sample(angle_sample(tilt));
            end else if (pick < 80) begin
                run_len = $urandom_range(1, 6);
                repeat (run_len) begin
                    v = int'($urandom_range(0, 2046)) - 1023;
                    send_sample(v[SAMPLE_W-1:0]);
                end
            end else begin
                run_len = $urandom_range(1, 8);
                repeat (run_len) send_sample(SAMPLE_W'($urandom));
            end
        end
        calm = 1'b0;

        drain_messages();
        repeat (20) @(negedge aclk);

        $display("Sent %0d samples; checked %0d modulation and %0d portamento messages.",
                 samples_sent, mod_seen, porta_seen);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/tltmod_pkg.sv
rtl/core/tltmod_map.sv
rtl/core/tltmod_queue.sv
rtl/core/tilt_to_modulation_controls.sv
verif/tilt_controls_checker.sv
verif/tb_top.sv
